### rtl/a2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package a2c_pkg;

   // counter width of an open run and width of the run_length field
   localparam int LENGTH_BITS     = 20;
   localparam int RUN_LENGTH_BITS = 20;

   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] LENGTH_ONE = LENGTH_BITS'(1);

   // column class codes
   localparam logic [1:0] CLASS_GAP     = 2'd1;
   localparam logic [1:0] CLASS_MISSING = 2'd2;

   // run queue between front and back
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_MATCH         = 3'd0,
      OP_REF_GAP       = 3'd1,
      OP_QUERY_GAP     = 3'd2,
      OP_REF_SKIPPED   = 3'd3,
      OP_QUERY_SKIPPED = 3'd4,
      OP_BOTH_GAP      = 3'd5
   } run_op_type;

   typedef struct packed {
      run_op_type                 op;
      logic [RUN_LENGTH_BITS-1:0] length;
      logic                       final_run;
      logic                       overflow;
   } run_rec_type;

   // up to two finished runs per column, packed from rec0 upward
   typedef struct packed {
      logic [1:0]  count;
      run_rec_type rec0;
      run_rec_type rec1;
   } push_type;

endpackage

`default_nettype wire

### rtl/a2c_front.sv
`timescale 1ns / 1ps
`default_nettype none

module a2c_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_ref_class,
   input  wire logic [1:0]          req_query_class,
   input  wire logic                req_last_column,
   input  wire logic                space_ok,
   output a2c_pkg::push_type        push
);

   a2c_pkg::run_op_type               cur_ff, cur_in;
   logic [a2c_pkg::LENGTH_BITS-1:0]   len_ff, len_in;
   logic                              any_ff, any_in;
   logic                              ovf_ff, ovf_in;

   logic                 accept;
   a2c_pkg::run_op_type  op;
   logic                 active;
   logic                 same;
   logic                 emit_a;
   a2c_pkg::run_rec_type rec_a;
   a2c_pkg::run_rec_type rec_f;

   function automatic a2c_pkg::run_op_type classify(input logic [1:0] r, input logic [1:0] q);
      if (r == a2c_pkg::CLASS_GAP)
         return (q == a2c_pkg::CLASS_GAP) ? a2c_pkg::OP_BOTH_GAP : a2c_pkg::OP_REF_GAP;
      if (r == a2c_pkg::CLASS_MISSING)
         return a2c_pkg::OP_QUERY_SKIPPED;
      if (q == a2c_pkg::CLASS_GAP)
         return a2c_pkg::OP_QUERY_GAP;
      if (q == a2c_pkg::CLASS_MISSING)
         return a2c_pkg::OP_REF_SKIPPED;
      return a2c_pkg::OP_MATCH;
   endfunction

   function automatic logic [a2c_pkg::RUN_LENGTH_BITS-1:0] len_field(
      input logic [a2c_pkg::LENGTH_BITS-1:0] l);
      logic [31:0] w;
      w = 32'(l);
      return w[a2c_pkg::RUN_LENGTH_BITS-1:0];
   endfunction

   assign req_ready = space_ok;
   assign accept    = req_valid & space_ok;

   always_comb begin
      op     = classify(req_ref_class, req_query_class);
      active = (len_ff != '0);
      same   = active && (op == cur_ff);

      cur_in = cur_ff;
      len_in = len_ff;
      any_in = any_ff;
      ovf_in = ovf_ff;
      emit_a = 1'b0;
      push   = '0;

      // a leading query-gap run reads as ref skipped
      rec_a.op        = (cur_ff == a2c_pkg::OP_QUERY_GAP && !any_ff) ?
                        a2c_pkg::OP_REF_SKIPPED : cur_ff;
      rec_a.length    = len_field(len_ff);
      rec_a.final_run = 1'b0;
      rec_a.overflow  = ovf_ff;

      if (accept) begin
         if (same) begin
            if (len_ff == a2c_pkg::LENGTH_MAX) begin
               ovf_in = 1'b1;
            end else begin
               len_in = len_ff + a2c_pkg::LENGTH_ONE;
            end
         end else begin
            cur_in = op;
            len_in = a2c_pkg::LENGTH_ONE;
            ovf_in = 1'b0;
            if (active) begin
               emit_a = 1'b1;
               any_in = 1'b1;
            end
         end
      end

      // final run is built from the updated state; a trailing query gap reads as ref skipped
      rec_f.op        = (cur_in == a2c_pkg::OP_QUERY_GAP) ? a2c_pkg::OP_REF_SKIPPED : cur_in;
      rec_f.length    = len_field(len_in);
      rec_f.final_run = 1'b1;
      rec_f.overflow  = ovf_in;

      if (emit_a) begin
         push.rec0  = rec_a;
         push.count = 2'd1;
      end

      if (accept && req_last_column) begin
         if (emit_a) begin
            push.rec1  = rec_f;
            push.count = 2'd2;
         end else begin
            push.rec0  = rec_f;
            push.count = 2'd1;
         end
         cur_in = a2c_pkg::OP_QUERY_SKIPPED;
         len_in = '0;
         any_in = 1'b0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= a2c_pkg::OP_QUERY_SKIPPED;
         len_ff <= '0;
         any_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
         len_ff <= len_in;
         any_ff <= any_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

`default_nettype wire

### rtl/a2c_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module a2c_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire a2c_pkg::push_type     push,
   input  wire logic                  pop,
   output logic                       space_ok,
   output logic                       not_empty,
   output a2c_pkg::run_rec_type       head
);

   a2c_pkg::run_rec_type mem [a2c_pkg::QUEUE_DEPTH];

   logic [a2c_pkg::QUEUE_PTR_BITS-1:0]   wr_ff, wr_in;
   logic [a2c_pkg::QUEUE_PTR_BITS-1:0]   rd_ff, rd_in;
   logic [a2c_pkg::QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [a2c_pkg::QUEUE_PTR_BITS-1:0]   wr_next;

   // room for a full two-run push, independent of this cycle's pop
   assign space_ok  = (count_ff <= a2c_pkg::QUEUE_COUNT_BITS'(a2c_pkg::QUEUE_DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ff];
   assign wr_next   = wr_ff + a2c_pkg::QUEUE_PTR_BITS'(1);

   always_comb begin
      wr_in    = wr_ff + a2c_pkg::QUEUE_PTR_BITS'(push.count);
      rd_in    = pop ? rd_ff + a2c_pkg::QUEUE_PTR_BITS'(1) : rd_ff;
      count_in = count_ff + a2c_pkg::QUEUE_COUNT_BITS'(push.count)
                 - a2c_pkg::QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.rec0;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/a2c_back.sv
`timescale 1ns / 1ps
`default_nettype none

module a2c_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        not_empty,
   input  wire a2c_pkg::run_rec_type        head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [2:0]                       rsp_run_op,
   output logic [a2c_pkg::RUN_LENGTH_BITS-1:0] rsp_run_length,
   output logic                             rsp_final_run,
   output logic                             rsp_length_overflow
);

   logic                 valid_ff, valid_in;
   a2c_pkg::run_rec_type rec_ff, rec_in;

   always_comb begin
      pop      = not_empty & (~valid_ff | rsp_ready);
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (pop) begin
         valid_in = 1'b1;
         rec_in   = head;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_run_op          = rec_ff.op;
   assign rsp_run_length      = rec_ff.length;
   assign rsp_final_run       = rec_ff.final_run;
   assign rsp_length_overflow = rec_ff.overflow;

endmodule

`default_nettype wire

### rtl/alignment_to_cigar_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_ready  | ref_class, query_class, last_column
// rsp      | out       | rsp_valid/rsp_ready  | run_op, run_length, final_run, length_overflow
//
// A column is taken each cycle req_ready is high; the front's run tracker updates in that cycle.
// Finished runs (zero to two per column) pass a 4-entry queue to a registered output,
// so runs reach rsp via the queue and output register, one per cycle while rsp_ready is high.
// req_ready drops while the queue has fewer than two free entries.
// Synchronous reset clears the run state, the queue pointers and rsp_valid.

module alignment_to_cigar_encoder_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_ref_class,
   input  wire logic [1:0]                  req_query_class,
   input  wire logic                        req_last_column,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [2:0]                       rsp_run_op,
   output logic [a2c_pkg::RUN_LENGTH_BITS-1:0] rsp_run_length,
   output logic                             rsp_final_run,
   output logic                             rsp_length_overflow
);

   a2c_pkg::push_type    push;
   a2c_pkg::run_rec_type head;
   logic                 space_ok;
   logic                 not_empty;
   logic                 pop;

   a2c_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ref_class   (req_ref_class),
      .req_query_class (req_query_class),
      .req_last_column (req_last_column),
      .space_ok        (space_ok),
      .push            (push)
   );

   a2c_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .space_ok  (space_ok),
      .not_empty (not_empty),
      .head      (head)
   );

   a2c_back u_back (
      .clock               (clock),
      .reset               (reset),
      .not_empty           (not_empty),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_run_op          (rsp_run_op),
      .rsp_run_length      (rsp_run_length),
      .rsp_final_run       (rsp_final_run),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule

`default_nettype wire

### tb/tb_alignment_to_cigar_encoder_top.sv
`timescale 1ns / 1ps

module tb_alignment_to_cigar_encoder_top;
   import a2c_pkg::*;

   localparam logic [1:0] CLASS_BASE  = 2'd0;
   localparam logic [1:0] CLASS_THREE = 2'd3;   // undefined code, counts as a base
   localparam int IDLE_PCT      = 29;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 200;
   localparam int RANDOM_COLUMNS = 500;
   localparam int MAX_PRINTED   = 40;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_ref_class = CLASS_BASE;
   logic [1:0]                 req_query_class = CLASS_BASE;
   logic                       req_last_column = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [2:0]                 rsp_run_op;
   logic [RUN_LENGTH_BITS-1:0] rsp_run_length;
   logic                       rsp_final_run;
   logic                       rsp_length_overflow;

   // idle controls and hold-off requests from the test sequence
   bit send_idle_en = 1'b1;
   bit rsp_idle_en = 1'b1;
   int hold_requests = 0;

   // run tracker mirror
   run_op_type             open_op = OP_QUERY_SKIPPED;
   logic [LENGTH_BITS-1:0] open_length = '0;
   bit                     run_emitted = 1'b0;
   bit                     open_saturated = 1'b0;

   run_rec_type pending_runs[$];
   int          error_count = 0;
   int          columns_sent = 0;
   int          alignments_sent = 0;
   int          runs_checked = 0;

   alignment_to_cigar_encoder_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_ref_class       (req_ref_class),
      .req_query_class     (req_query_class),
      .req_last_column     (req_last_column),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_run_op          (rsp_run_op),
      .rsp_run_length      (rsp_run_length),
      .rsp_final_run       (rsp_final_run),
      .rsp_length_overflow (rsp_length_overflow)
   );

   always #1 clock = ~clock;

   function automatic run_op_type column_op(input logic [1:0] r, input logic [1:0] q);
      if (r == CLASS_GAP) return (q == CLASS_GAP) ? OP_BOTH_GAP : OP_REF_GAP;
      if (r == CLASS_MISSING) return OP_QUERY_SKIPPED;
      if (q == CLASS_GAP) return OP_QUERY_GAP;
      if (q == CLASS_MISSING) return OP_REF_SKIPPED;
      return OP_MATCH;
   endfunction

   task automatic close_run(input bit is_final);
      run_rec_type rec;
      rec.op = open_op;
      // a query gap at either end of the alignment is reported as ref skipped
      if (open_op == OP_QUERY_GAP && (!run_emitted || is_final)) rec.op = OP_REF_SKIPPED;
      rec.length = RUN_LENGTH_BITS'(open_length);
      rec.final_run = is_final;
      rec.overflow = open_saturated;
      pending_runs.insert(pending_runs.size(), rec);
      run_emitted = 1'b1;
   endtask

   task automatic track_column(input logic [1:0] r, input logic [1:0] q, input logic last);
      run_op_type op;
      op = column_op(r, q);
      if (open_length != '0 && op == open_op) begin
         if (open_length == LENGTH_MAX) open_saturated = 1'b1;
         else open_length = open_length + LENGTH_ONE;
      end else begin
         if (open_length != '0) close_run(1'b0);
         open_op = op;
         open_length = LENGTH_ONE;
         open_saturated = 1'b0;
      end
      if (last) begin
         close_run(1'b1);
         open_op = OP_QUERY_SKIPPED;
         open_length = '0;
         run_emitted = 1'b0;
         open_saturated = 1'b0;
         alignments_sent++;
      end
   endtask

   // called at a falling edge, returns at a falling edge with valid low
   task automatic send_column(input logic [1:0] r, input logic [1:0] q, input logic last);
      while (send_idle_en && $urandom_range(99) < IDLE_PCT) @(negedge clock);
      req_valid = 1'b1;
      req_ref_class = r;
      req_query_class = q;
      req_last_column = last;
      do @(posedge clock); while (!req_ready);
      track_column(r, q, last);
      columns_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
   endtask

   // receiver: random idling plus long hold-offs on request
   always @(negedge clock) begin : rsp_side
      int hold_left;
      int holds_seen;
      if (hold_requests != holds_seen) begin
         holds_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = !(rsp_idle_en && $urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin : check_runs
      run_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_runs.size() == 0) begin
            report_mismatch("unexpected run, op", rsp_run_op, -1);
         end else begin
            want = pending_runs.pop_front();
            runs_checked++;
            if (rsp_run_op !== want.op) report_mismatch("run_op", rsp_run_op, want.op);
            if (rsp_run_length !== want.length)
               report_mismatch("run_length", rsp_run_length, want.length);
            if (rsp_final_run !== want.final_run)
               report_mismatch("final_run", rsp_final_run, want.final_run);
            if (rsp_length_overflow !== want.overflow)
               report_mismatch("length_overflow", rsp_length_overflow, want.overflow);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   // all class pairs, including the undefined code, in one alignment
   task automatic test_class_pairs();
      for (int r = 0; r < 4; r++)
         for (int q = 0; q < 4; q++)
            send_column(2'(r), 2'(q), (r == 3 && q == 3));
   endtask

   task automatic test_edge_runs();
      // single-column alignment made of a query gap
      send_column(CLASS_BASE, CLASS_GAP, 1'b1);
      // leading query gap run
      send_column(CLASS_BASE, CLASS_GAP, 1'b0);
      send_column(CLASS_BASE, CLASS_GAP, 1'b0);
      send_column(CLASS_BASE, CLASS_BASE, 1'b1);
      // trailing query gap run
      send_column(CLASS_THREE, CLASS_BASE, 1'b0);
      send_column(CLASS_BASE, CLASS_GAP, 1'b0);
      send_column(CLASS_BASE, CLASS_GAP, 1'b1);
      // op change on the last column yields two runs at once
      send_column(CLASS_MISSING, CLASS_MISSING, 1'b0);
      send_column(CLASS_MISSING, CLASS_BASE, 1'b0);
      send_column(CLASS_GAP, CLASS_GAP, 1'b1);
      // query gap in the middle stays a query gap
      send_column(CLASS_BASE, CLASS_BASE, 1'b0);
      send_column(CLASS_BASE, CLASS_GAP, 1'b0);
      send_column(CLASS_BASE, CLASS_MISSING, 1'b1);
   endtask

   // long stretch with no idling on either side
   task automatic test_back_to_back();
      send_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      for (int i = 0; i < 60; i++)
         send_column(((i % 3) == 0) ? CLASS_MISSING : CLASS_BASE, CLASS_BASE, (i % 20) == 19);
      send_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   // receiver stalls while each column after an alignment's first closes a run, so the queue fills up
   task automatic test_backpressure();
      send_idle_en = 1'b0;
      hold_requests++;
      for (int i = 0; i < 40; i++)
         send_column((i % 2) ? CLASS_GAP : CLASS_BASE, CLASS_BASE, (i % 10) == 9);
      send_idle_en = 1'b1;
   endtask

   task automatic test_random_alignments();
      int          len;
      logic [1:0]  r;
      logic [1:0]  q;
      int          target;
      target = columns_sent + RANDOM_COLUMNS;
      while (columns_sent < target) begin
         if ($urandom_range(99) < 85) begin
            // well-formed alignment: runs of repeated classes, ends with last
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
            r = 2'($urandom_range(3));
            q = 2'($urandom_range(3));
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < 35) begin
                  r = 2'($urandom_range(3));
                  q = 2'($urandom_range(3));
               end
               send_column(r, q, i == len - 1);
            end
         end else begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
               send_column(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
         end
      end
      // close whatever the noise left open
      send_column(CLASS_BASE, CLASS_BASE, 1'b1);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_class_pairs();
      test_edge_runs();
      test_back_to_back();
      test_backpressure();
      test_random_alignments();
      while (pending_runs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d columns in %0d alignments, checked %0d runs.",
               columns_sent, alignments_sent, runs_checked);
      $display("Covered all class pairs, edge query gaps, a gap-free stretch and output stalls.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/a2c_pkg.sv
rtl/a2c_front.sv
rtl/a2c_queue.sv
rtl/a2c_back.sv
rtl/alignment_to_cigar_encoder_top.sv
tb/tb_alignment_to_cigar_encoder_top.sv
